FILE: src/assert_macros.svh
// Assertion macros for the RTL files of the Gerstner wave block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define GWD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gwd assertion failed");

// Same, on the block's own clock and reset.
`define GWD_ASSERT_CLK(label, prop) `GWD_ASSERT(label, i_clk, i_rst_n, prop)

`endif

FILE: src/gwd_pkg.sv
// Package of the Gerstner wave displacement block: types, constants, register codes.
// No dependencies; used by every module of the block.
package gwd_pkg;

    localparam int NUM_WAVES = 4;
    localparam int WAVE_REGS = 4;
    localparam int NUM_CELLS = (NUM_WAVES < WAVE_REGS) ? NUM_WAVES : WAVE_REGS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_NOW = 3'd4;
    localparam int WAVE_IDX_W = $clog2(WAVE_REGS);

    // Sine approximation constants, Q14.
    localparam logic [14:0] Q14_ONE = 15'd16384;
    localparam logic [14:0] SIN_C1  = 15'd25736;
    localparam logic [13:0] SIN_C2  = 14'd10512;
    localparam logic [10:0] SIN_C3  = 11'd1160;
    localparam int SC_LAT = 4;

    // 2^32 / (2*pi), rounded.
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    // Pipeline depths inside one cell.
    localparam int XZ_DLY    = 4;
    localparam int DIV_STEPS = 33;
    localparam int CELL_LAT  = XZ_DLY + 3 + DIV_STEPS + 1 + SC_LAT + 3;

    localparam int ACC_W = 52;
    typedef logic signed [ACC_W-1:0] t_acc_val;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } t_out;

    typedef struct packed {
        logic        [15:0] dir;
        logic signed [15:0] spd;
        logic        [15:0] len;
        logic        [15:0] amp;
    } t_wave;

    typedef struct packed {
        logic               vld;
        logic signed [15:0] x;
        logic signed [15:0] z;
    } t_link;

    typedef struct packed {
        logic     vld;
        t_acc_val ax;
        t_acc_val ay;
        t_acc_val az;
    } t_acc;

    typedef struct packed {
        logic        vld;
        logic        neg;
        logic [15:0] rem;
        logic [DIV_STEPS-1:0] dvd;
        logic [15:0] q;
    } t_div;

endpackage

FILE: src/gwd_sincos.sv
// Pipelined sine and cosine of a 16-bit binary angle, signed Q14 results.
// Depends on gwd_pkg for the polynomial constants.
module gwd_sincos (
    input  logic               i_clk,
    input  logic        [15:0] i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    logic [15:0] ang [2];
    logic [14:0] u0  [2];
    logic [29:0] m1  [2];
    logic [25:0] m2  [2];
    logic [28:0] m3  [2];
    logic [29:0] m4  [2];
    logic [15:0] v4  [2];
    logic [14:0] c4  [2];

    logic [1:0]  r_q1 [2], r_q2 [2], r_q3 [2];
    logic [14:0] r_u1 [2], r_u2 [2], r_u3 [2];
    logic [14:0] r_s1 [2], r_s2 [2];
    logic [13:0] r_t2 [2];
    logic [14:0] r_t3 [2];
    logic signed [15:0] r_y [2];

    // Lane 0 is the sine, lane 1 the cosine as the sine a quarter turn on.
    assign ang[0] = i_angle;
    assign ang[1] = i_angle + 16'(gwd_pkg::Q14_ONE);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            u0[l] = ang[l][14] ? (gwd_pkg::Q14_ONE - {1'b0, ang[l][13:0]})
                               : {1'b0, ang[l][13:0]};
            m1[l] = u0[l] * u0[l];
            m2[l] = gwd_pkg::SIN_C3 * r_s1[l];
            m3[l] = r_t2[l] * r_s2[l];
            m4[l] = r_t3[l] * r_u3[l];
            v4[l] = m4[l][29:14];
            c4[l] = (v4[l] > 16'(gwd_pkg::Q14_ONE)) ? gwd_pkg::Q14_ONE : v4[l][14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_q1[l] <= ang[l][15:14];
            r_u1[l] <= u0[l];
            r_s1[l] <= m1[l][28:14];
            r_q2[l] <= r_q1[l];
            r_u2[l] <= r_u1[l];
            r_s2[l] <= r_s1[l];
            r_t2[l] <= gwd_pkg::SIN_C2 - 14'(m2[l][25:14]);
            r_q3[l] <= r_q2[l];
            r_u3[l] <= r_u2[l];
            r_t3[l] <= gwd_pkg::SIN_C1 - m3[l][28:14];
            r_y[l]  <= r_q3[l][1] ? -$signed({1'b0, c4[l]}) : $signed({1'b0, c4[l]});
        end
    end

    assign o_sin = r_y[0];
    assign o_cos = r_y[1];

endmodule

FILE: src/gwd_divstep.sv
// One restoring division step: one quotient bit per stage of the divider chain.
// Depends on gwd_pkg for the t_div stage record.
module gwd_divstep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_len,
    input  gwd_pkg::t_div i_d,
    output gwd_pkg::t_div o_d
);

    logic [16:0] r17;
    logic [16:0] diff;
    logic        ge;
    gwd_pkg::t_div n_d, r_d;

    assign r17  = {i_d.rem, i_d.dvd[gwd_pkg::DIV_STEPS-1]};
    assign diff = r17 - {1'b0, i_len};
    assign ge   = (r17 >= {1'b0, i_len});

    always_comb begin
        n_d     = i_d;
        n_d.rem = ge ? diff[15:0] : r17[15:0];
        n_d.dvd = {i_d.dvd[gwd_pkg::DIV_STEPS-2:0], 1'b0};
        n_d.q   = {i_d.q[14:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d.neg <= n_d.neg;
        r_d.rem <= n_d.rem;
        r_d.dvd <= n_d.dvd;
        r_d.q   <= n_d.q;
    end

    assign o_d = r_d;

endmodule

FILE: src/gwd_cell.sv
// One wave cell of the chain: phase, trig, divider and this wave's share of the sums.
// Depends on gwd_pkg, gwd_sincos and gwd_divstep.
module gwd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gwd_pkg::t_wave i_wave,
    input  logic [31:0]    i_time,
    input  gwd_pkg::t_link i_link,
    output gwd_pkg::t_link o_link,
    input  gwd_pkg::t_acc  i_acc,
    output gwd_pkg::t_acc  o_acc
);

    // Direction trig and time phase follow the registers continuously.
    logic signed [15:0] cd, sd, cph, sph;
    logic signed [48:0] tp;
    logic        [55:0] p56;
    logic        [57:0] phc, plc;
    logic        [55:0] tsum;
    logic        [27:0] r_phc;
    logic        [57:0] r_plc;
    logic signed [48:0] r_tp;
    logic        [15:0] r_tt;

    gwd_sincos u_dir (.i_clk(i_clk), .i_angle(i_wave.dir), .o_sin(sd), .o_cos(cd));

    assign tp   = i_wave.spd * $signed({1'b0, i_time});
    assign p56  = {{7{r_tp[48]}}, r_tp};
    assign phc  = p56[55:28] * gwd_pkg::INV_TWO_PI_Q32;
    assign plc  = p56[27:0] * gwd_pkg::INV_TWO_PI_Q32;
    assign tsum = {r_phc, 28'd0} + r_plc[55:0];

    always_ff @(posedge i_clk) begin
        r_tp  <= tp;
        r_phc <= phc[27:0];
        r_plc <= plc;
        r_tt  <= tsum[55:40];
    end

    // Item path.
    typedef struct packed {
        logic vld;
        logic signed [31:0] mx;
        logic signed [31:0] mz;
    } t_mul;
    typedef struct packed {
        logic vld;
        logic signed [31:0] d;
    } t_dot;
    typedef struct packed {
        logic vld;
        logic neg;
        logic [gwd_pkg::DIV_STEPS-1:0] mag;
    } t_abs;
    typedef struct packed {
        logic vld;
        logic signed [32:0] px;
        logic signed [32:0] pz;
        logic signed [32:0] py;
        logic signed [15:0] cph;
    } t_pa;
    typedef struct packed {
        logic vld;
        gwd_pkg::t_acc_val cx;
        gwd_pkg::t_acc_val cy;
        gwd_pkg::t_acc_val cz;
    } t_pb;

    gwd_pkg::t_link r_xd [gwd_pkg::XZ_DLY];
    t_mul r_m;
    t_dot r_d;
    t_abs r_a;
    logic        r_pvld;
    logic [15:0] r_phase;
    logic [gwd_pkg::SC_LAT-1:0] r_pv;
    t_pa r_pa;
    t_pb r_pb;
    gwd_pkg::t_acc r_acc;

    logic signed [31:0] mx_w, mz_w;
    logic signed [33:0] dx, n4, nm;
    gwd_pkg::t_div div_w [gwd_pkg::DIV_STEPS+1];
    logic [15:0] spq;
    logic signed [32:0] px_w, pz_w, py_w;
    logic signed [48:0] cx_w, cz_w;
    logic no_wave;

    assign mx_w = r_xd[gwd_pkg::XZ_DLY-1].x * cd;
    assign mz_w = r_xd[gwd_pkg::XZ_DLY-1].z * sd;
    assign dx   = {{2{r_d.d[31]}}, r_d.d};
    assign n4   = dx <<< 2;
    assign nm   = -n4;

    assign div_w[0] = '{vld: r_a.vld, neg: r_a.neg, rem: '0, dvd: r_a.mag, q: '0};

    for (genvar s = 0; s < gwd_pkg::DIV_STEPS; s++) begin : g_div
        gwd_divstep u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_len  (i_wave.len),
            .i_d    (div_w[s]),
            .o_d    (div_w[s+1])
        );
    end

    // Quotient truncates toward zero; only its low 16 bits matter modulo a turn.
    assign spq = div_w[gwd_pkg::DIV_STEPS].neg ? (16'd0 - div_w[gwd_pkg::DIV_STEPS].q)
                                               : div_w[gwd_pkg::DIV_STEPS].q;

    gwd_sincos u_ph (.i_clk(i_clk), .i_angle(r_phase), .o_sin(sph), .o_cos(cph));

    assign px_w    = $signed({1'b0, i_wave.amp}) * cd;
    assign pz_w    = $signed({1'b0, i_wave.amp}) * sd;
    assign py_w    = $signed({1'b0, i_wave.amp}) * sph;
    assign cx_w    = r_pa.px * r_pa.cph;
    assign cz_w    = r_pa.pz * r_pa.cph;
    assign no_wave = (i_wave.len == 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gwd_pkg::XZ_DLY; k++) r_xd[k].vld <= 1'b0;
            r_m.vld   <= 1'b0;
            r_d.vld   <= 1'b0;
            r_a.vld   <= 1'b0;
            r_pvld    <= 1'b0;
            r_pv      <= '0;
            r_pa.vld  <= 1'b0;
            r_pb.vld  <= 1'b0;
            r_acc.vld <= 1'b0;
        end else begin
            r_xd[0].vld <= i_link.vld;
            for (int k = 1; k < gwd_pkg::XZ_DLY; k++) r_xd[k].vld <= r_xd[k-1].vld;
            r_m.vld   <= r_xd[gwd_pkg::XZ_DLY-1].vld;
            r_d.vld   <= r_m.vld;
            r_a.vld   <= r_d.vld;
            r_pvld    <= div_w[gwd_pkg::DIV_STEPS].vld;
            r_pv      <= {r_pv[gwd_pkg::SC_LAT-2:0], r_pvld};
            r_pa.vld  <= r_pv[gwd_pkg::SC_LAT-1];
            r_pb.vld  <= r_pa.vld;
            r_acc.vld <= r_pb.vld;
        end
        r_xd[0].x <= i_link.x;
        r_xd[0].z <= i_link.z;
        for (int k = 1; k < gwd_pkg::XZ_DLY; k++) begin
            r_xd[k].x <= r_xd[k-1].x;
            r_xd[k].z <= r_xd[k-1].z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m.mx   <= mx_w;
        r_m.mz   <= mz_w;
        r_d.d    <= r_m.mx + r_m.mz;
        r_a.neg  <= n4[33];
        r_a.mag  <= n4[33] ? nm[gwd_pkg::DIV_STEPS-1:0] : n4[gwd_pkg::DIV_STEPS-1:0];
        r_phase  <= spq - r_tt;
        r_pa.px  <= px_w;
        r_pa.pz  <= pz_w;
        r_pa.py  <= py_w;
        r_pa.cph <= cph;
        r_pb.cx  <= no_wave ? '0 : gwd_pkg::t_acc_val'(cx_w);
        r_pb.cz  <= no_wave ? '0 : gwd_pkg::t_acc_val'(cz_w);
        r_pb.cy  <= no_wave ? '0 : (gwd_pkg::t_acc_val'(r_pa.py) <<< 14);
        r_acc.ax <= i_acc.ax + r_pb.cx;
        r_acc.ay <= i_acc.ay + r_pb.cy;
        r_acc.az <= i_acc.az + r_pb.cz;
    end

    assign o_link = r_xd[0];
    assign o_acc  = r_acc;

endmodule

FILE: src/gerstner_wave_displacement.sv
// Top level of the Gerstner wave displacement block: configuration registers,
// the chain of wave cells and the rounding output stage. Depends on gwd_pkg,
// gwd_cell and assert_macros.svh.
//
// Usage. A grid point request (pos_x, pos_z, signed Q8.8) is taken on i_req at a
// rising edge where start is high and busy is low. busy is high only in reset and
// until the run flag is set after it, then a request can be taken in every cycle.
// Each request gives exactly one result (out_x, out_y, out_z, signed Q8.8,
// rounded half up and saturated) on o_result, marked by o_strobe for one cycle.
// The receiver cannot stall: results leave in request order as they come.
// Throughput is one request per cycle. Each cell computes one wave over a
// 48-stage pipeline, the 33-step restoring divider by the wavelength being its
// longest part; cell k works on a request in the cycle after cell k-1 and adds its
// share to the running sums that cell k-1 hands it.
// Configuration writes (wave_0..wave_3, time_now) arrive on the cfg channel,
// which is always ready; an index beyond time_now is ignored. Direction trig
// and the time phase are recomputed continuously from the registers, so they
// must only change while no request is in flight.
// Reset clears the configuration, every wave to zero, and empties the pipeline.
`include "assert_macros.svh"

module gerstner_wave_displacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gwd_pkg::t_in                      i_req,
    output logic                              o_strobe,
    output gwd_pkg::t_out                     o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gwd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);

    localparam int DLY     = gwd_pkg::NUM_CELLS + gwd_pkg::CELL_LAT - 1;
    localparam int OUT_LAT = gwd_pkg::NUM_CELLS + gwd_pkg::CELL_LAT + 1;

    gwd_pkg::t_wave r_wave [gwd_pkg::WAVE_REGS];
    logic [31:0]    r_time;
    logic           r_run;
    logic           accept;

    gwd_pkg::t_link r_in;
    gwd_pkg::t_link r_dly [DLY];
    gwd_pkg::t_link link [gwd_pkg::NUM_CELLS+1];
    gwd_pkg::t_acc  acc  [gwd_pkg::NUM_CELLS+1];

    logic          r_strobe;
    gwd_pkg::t_out r_out;
    gwd_pkg::t_acc_val sx, sy, sz;

    assign busy        = !r_run;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gwd_pkg::WAVE_REGS; k++) r_wave[k] <= '0;
            r_time <= '0;
            r_run  <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index inside {[gwd_pkg::REG_WAVE_0:gwd_pkg::REG_WAVE_3]}) begin
                    r_wave[i_cfg_index[gwd_pkg::WAVE_IDX_W-1:0]] <= i_cfg_data;
                end else if (i_cfg_index == gwd_pkg::REG_TIME_NOW) begin
                    r_time <= i_cfg_data[31:0];
                end
            end
        end
    end

    // Request register and the delay line that brings x and z to the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
            for (int k = 0; k < DLY; k++) r_dly[k].vld <= 1'b0;
        end else begin
            r_in.vld <= accept;
            r_dly[0].vld <= r_in.vld;
            for (int k = 1; k < DLY; k++) r_dly[k].vld <= r_dly[k-1].vld;
        end
        r_in.x <= i_req.pos_x;
        r_in.z <= i_req.pos_z;
        r_dly[0].x <= r_in.x;
        r_dly[0].z <= r_in.z;
        for (int k = 1; k < DLY; k++) begin
            r_dly[k].x <= r_dly[k-1].x;
            r_dly[k].z <= r_dly[k-1].z;
        end
    end

    // The chain of wave cells; the first one starts from empty sums.
    assign link[0] = r_in;
    assign acc[0]  = '0;

    for (genvar c = 0; c < gwd_pkg::NUM_CELLS; c++) begin : g_cell
        gwd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_wave (r_wave[c]),
            .i_time (r_time),
            .i_link (link[c]),
            .o_link (link[c+1]),
            .i_acc  (acc[c]),
            .o_acc  (acc[c+1])
        );
    end

    // Shift a biased Q40 sum down to Q8.8 and saturate.
    function automatic logic signed [15:0] rnd_sat(input gwd_pkg::t_acc_val v);
        logic signed [gwd_pkg::ACC_W-33:0] q;
        q = v[gwd_pkg::ACC_W-1:32];
        if (q > 32767) begin
            rnd_sat = 16'sh7FFF;
        end else if (q < -32768) begin
            rnd_sat = 16'sh8000;
        end else begin
            rnd_sat = 16'(q);
        end
    endfunction

    // The grid point enters in Q40 with the rounding half folded into its low bits.
    assign sx = acc[gwd_pkg::NUM_CELLS].ax
              + ((gwd_pkg::t_acc_val'(r_dly[DLY-1].x) <<< 32) | (gwd_pkg::t_acc_val'(1) <<< 31));
    assign sz = acc[gwd_pkg::NUM_CELLS].az
              + ((gwd_pkg::t_acc_val'(r_dly[DLY-1].z) <<< 32) | (gwd_pkg::t_acc_val'(1) <<< 31));
    assign sy = acc[gwd_pkg::NUM_CELLS].ay + (gwd_pkg::t_acc_val'(1) <<< 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= acc[gwd_pkg::NUM_CELLS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.out_x <= rnd_sat(sx);
        r_out.out_y <= rnd_sat(sy);
        r_out.out_z <= rnd_sat(sz);
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // A result only ever leaves in answer to an accepted request.
    `GWD_ASSERT_CLK(a_strobe_latency, o_strobe |-> $past(accept, OUT_LAT))
    // The sums from the cell chain line up with the delayed grid point.
    `GWD_ASSERT_CLK(a_chain_align, acc[gwd_pkg::NUM_CELLS].vld == r_dly[DLY-1].vld)
    // Right after reset the pipeline is empty.
    `GWD_ASSERT_CLK(a_empty_after_reset, !r_run |=> !o_strobe)

endmodule

FILE: test/gerstner_wave_displacement_test.sv
// Self-checking testbench of the Gerstner wave displacement block.
// Depends on gwd_pkg and gerstner_wave_displacement; predicts each grid point's
// displaced position in integer arithmetic and checks every result in order.
module gerstner_wave_displacement_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gwd_pkg::*;

    // Pipeline depth with four waves, plus margin for the settle waits.
    localparam int PIPE_LAT = NUM_CELLS + 49;
    localparam int SETTLE = PIPE_LAT + 20;
    localparam int WATCHDOG = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in i_req = '0;
    logic o_strobe;
    t_out o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    gerstner_wave_displacement dut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [63:0] wave_regs [WAVE_REGS];
    logic [31:0] anim_time;

    t_in pending_points[$];
    t_out expected_points[$];
    int sender_idle_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    // Quarter-wave polynomial sine, signed Q14.
    function automatic int sine_q14(input logic [15:0] ang);
        logic [1:0] quad;
        longint u, u2, t;
        quad = ang[15:14];
        u = ang[13:0];
        if (quad[0]) u = 16384 - u;
        u2 = (u * u) >>> 14;
        t = (1160 * u2) >>> 14;
        t = 10512 - t;
        t = (t * u2) >>> 14;
        t = 25736 - t;
        t = (t * u) >>> 14;
        if (t > 16384) t = 16384;
        if (quad[1]) t = -t;
        return int'(t);
    endfunction

    function automatic logic [15:0] round_sat_q8_8(input longint acc);
        longint r;
        r = (acc + (longint'(1) << 31)) >>> 32;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_out displace_point(input t_in pt);
        longint ax, ay, az, amp, len, spd, cd, sd, d, sp, cph, sph;
        logic [63:0] tt;
        logic [127:0] tw;
        logic [15:0] phase;
        t_out r;
        ax = longint'(pt.pos_x) <<< 32;
        az = longint'(pt.pos_z) <<< 32;
        ay = 0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            amp = wave_regs[i][15:0];
            len = wave_regs[i][31:16];
            spd = longint'($signed(wave_regs[i][47:32]));
            if (len == 0) continue;
            cd = sine_q14(wave_regs[i][63:48] + 16'd16384);
            sd = sine_q14(wave_regs[i][63:48]);
            d = longint'(pt.pos_x) * cd + longint'(pt.pos_z) * sd;
            sp = (d * 4) / len;   // truncates toward zero
            tt = 64'(spd) * 64'(anim_time);
            tw = 128'(tt * 64'd683565276);
            tt = tw[103:40];
            phase = sp[15:0] - tt[15:0];
            cph = sine_q14(phase + 16'd16384);
            sph = sine_q14(phase);
            ax += amp * cd * cph;
            az += amp * sd * cph;
            ay += amp * sph * 16384;
        end
        r.out_x = round_sat_q8_8(ax);
        r.out_y = round_sat_q8_8(ay);
        r.out_z = round_sat_q8_8(az);
        return r;
    endfunction

    // Driver: takes the next grid point from the queue, idling at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(start && !busy) && start) begin
                // Request still waiting for busy to drop; hold it.
            end else if (pending_points.size() > 0
                         && $urandom_range(99) >= sender_idle_pct) begin
                start <= 1'b1;
                i_req <= pending_points.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Prediction is made when the request is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            expected_points.push_back(displace_point(i_req));
    end

    // Monitor: compares each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out exp_pt;
        if (i_rst_n && o_strobe) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                         o_result.out_x, o_result.out_y, o_result.out_z);
                fail_count++;
            end else begin
                exp_pt = expected_points.pop_front();
                if (o_result.out_x !== exp_pt.out_x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time,
                             exp_pt.out_x, o_result.out_x);
                    fail_count++;
                end
                if (o_result.out_y !== exp_pt.out_y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time,
                             exp_pt.out_y, o_result.out_y);
                    fail_count++;
                end
                if (o_result.out_z !== exp_pt.out_z) begin
                    $display("%0t: out_z expected %0d actual %0d", $time,
                             exp_pt.out_z, o_result.out_z);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no accepted request, no result and no configuration write.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Writes one register over the configuration channel and updates the shadow.
    // i_cfg_valid drops after each write, so back-to-back calls never collide.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < REG_TIME_NOW) wave_regs[idx[WAVE_IDX_W-1:0]] = val;
        else if (idx == REG_TIME_NOW) anim_time = val[31:0];
        @(posedge i_clk);
    endtask

    // Waits until every request has left the pipeline and its result has come.
    task automatic drain_pipeline();
        while (pending_points.size() > 0 || start || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_wave();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(6))
            0: w[31:16] = 16'd0;              // silent wave
            1: w[31:16] = 16'd1;              // shortest wavelength
            2: w[31:16] = 16'hFFFF;
            3: w[15:0] = 16'hFFFF;            // largest amplitude
            default: w[31:16] = 16'($urandom_range(4096, 64));
        endcase
        return w;
    endfunction

    task automatic queue_random_points(input int count);
        t_in pt;
        repeat (count) begin
            pt.pos_x = pick_coord();
            pt.pos_z = pick_coord();
            pending_points.push_back(pt);
        end
    endtask

    initial begin
        t_in pt;
        for (int i = 0; i < WAVE_REGS; i++) wave_regs[i] = '0;
        anim_time = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With every wave at its reset value the points pass through unchanged.
        pt.pos_x = 16'h8000; pt.pos_z = 16'h7FFF; pending_points.push_back(pt);
        pt.pos_x = 16'h0000; pt.pos_z = 16'hFFFF; pending_points.push_back(pt);
        drain_pipeline();

        // Mixed ocean: two moderate waves, a silent one (zero wavelength) and an extreme one.
        write_reg(REG_WAVE_0, {16'h0000, 16'h0100, 16'h0A00, 16'h0800});
        write_reg(REG_WAVE_0 + 3'd1, {16'h4000, 16'hFF00, 16'h1400, 16'h0400});
        write_reg(REG_WAVE_0 + 3'd2, {16'h8000, 16'h0200, 16'h0000, 16'h1000});
        write_reg(REG_WAVE_3, {16'hC000, 16'h8000, 16'h0001, 16'hFFFF});
        write_reg(REG_TIME_NOW, 64'h0003_8000);
        // An index beyond time_now must be ignored.
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        pt.pos_x = 16'h8000; pt.pos_z = 16'h8000; pending_points.push_back(pt);
        pt.pos_x = 16'h7FFF; pt.pos_z = 16'h7FFF; pending_points.push_back(pt);
        pt.pos_x = 16'h7FFF; pt.pos_z = 16'h8000; pending_points.push_back(pt);
        pt.pos_x = 16'h0000; pt.pos_z = 16'h0000; pending_points.push_back(pt);
        pt.pos_x = 16'h0001; pt.pos_z = 16'hFFFF; pending_points.push_back(pt);
        pt.pos_x = 16'h5555; pt.pos_z = 16'hAAAA; pending_points.push_back(pt);
        drain_pipeline();

        // Extreme settings: all-ones waves and time, then shortest wavelength.
        for (int i = 0; i < WAVE_REGS; i++) write_reg(REG_WAVE_0 + 3'(i), '1);
        write_reg(REG_TIME_NOW, 64'hFFFF_FFFF);
        queue_random_points(6);
        drain_pipeline();
        for (int i = 0; i < WAVE_REGS; i++)
            write_reg(REG_WAVE_0 + 3'(i), {16'(i * 16384), 16'h8000, 16'h0001, 16'hFFFF});
        queue_random_points(6);
        drain_pipeline();

        // Random phases, each under a fresh configuration and idle pattern.
        for (int ph = 0; ph < 12; ph++) begin
            sender_idle_pct = (ph < 4) ? 30 : (ph < 8) ? 66 : 0;
            for (int i = 0; i < WAVE_REGS; i++) write_reg(REG_WAVE_0 + 3'(i), pick_wave());
            write_reg(REG_TIME_NOW, 64'($urandom));
            queue_random_points(140);
            drain_pipeline();
        end

        // Back to reset-valued waves and zero time.
        for (int i = 0; i < WAVE_REGS; i++) write_reg(REG_WAVE_0 + 3'(i), '0);
        write_reg(REG_TIME_NOW, '0);
        queue_random_points(30);
        drain_pipeline();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
